// ===== sv/stn_pkg.sv =====
`default_nettype none
package stn_pkg;

	// sizes of the frame history
	localparam int MAX_BINS    = 1024;
	localparam int MAX_MEDIAN  = 32;
	localparam int HIST_FRAMES = 33;

	// derived widths
	localparam int MAG_W     = 16;
	localparam int BIN_W     = $clog2(MAX_BINS);
	localparam int NBIN_W    = $clog2(MAX_BINS + 1);
	localparam int SLOT_W    = $clog2(HIST_FRAMES);
	localparam int NFRM_W    = $clog2(HIST_FRAMES + 1);
	localparam int LEN_W     = $clog2(MAX_MEDIAN + 1);
	localparam int WIDX_W    = $clog2(MAX_MEDIAN);
	localparam int ADDR_W    = SLOT_W + BIN_W;
	localparam int DEPTH     = HIST_FRAMES * MAX_BINS;
	localparam int BITCNT_W  = $clog2(MAG_W);
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIME_LEN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_LEN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BINS      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIST      = 2'd3;

	// window of values for one median
	typedef logic [MAX_MEDIAN-1:0][MAG_W-1:0] win_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TGATH,
		ST_TSEL,
		ST_FGATH,
		ST_FSEL,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== sv/stn_store.sv =====
`default_nettype none
module stn_store (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [stn_pkg::ADDR_W-1:0] waddr,
	input  wire logic [stn_pkg::MAG_W-1:0]  wdata,
	input  wire logic [stn_pkg::ADDR_W-1:0] raddr,
	output logic      [stn_pkg::MAG_W-1:0]  rdata
);

	logic [stn_pkg::MAG_W-1:0] mem [stn_pkg::DEPTH];

	// one write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// one registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/stn_sel.sv =====
`default_nettype none
module stn_sel (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [stn_pkg::LEN_W-1:0]   n,
	input  wire stn_pkg::win_t               win,
	output logic                             done,
	output logic      [stn_pkg::MAG_W-1:0]   res
);

	logic                                 busy_q;
	logic [stn_pkg::BITCNT_W-1:0]         bit_q;
	logic [stn_pkg::MAX_MEDIAN-1:0]       mask_q;
	logic [stn_pkg::LEN_W-1:0]            k_q;
	logic [stn_pkg::MAG_W-1:0]            res_q;
	logic                                 done_q;
	logic [stn_pkg::MAX_MEDIAN-1:0]       col;
	logic [stn_pkg::MAX_MEDIAN-1:0]       zmask;
	logic [stn_pkg::MAX_MEDIAN-1:0]       init_mask;
	logic [stn_pkg::LEN_W-1:0]            c0;

	// current bit plane of the window and count of zeros among candidates
	always_comb begin
		for (int e = 0; e < stn_pkg::MAX_MEDIAN; e++) begin
			col[e]       = win[e][bit_q];
			init_mask[e] = (stn_pkg::LEN_W'(e) < n);
		end
		zmask = mask_q & ~col;
		c0    = stn_pkg::LEN_W'($countones(zmask));
	end

	// radix select of the middle element, msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= busy_q && (bit_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= stn_pkg::BITCNT_W'(stn_pkg::MAG_W - 1);
			end else if (busy_q) begin
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// candidate set, rank and result bits
	always_ff @(posedge clk) begin
		if (start) begin
			mask_q <= init_mask;
			k_q    <= n >> 1;
			res_q  <= '0;
		end else if (busy_q) begin
			if (k_q < c0) begin
				mask_q       <= zmask;
				res_q[bit_q] <= 1'b0;
			end else begin
				mask_q       <= mask_q & col;
				k_q          <= k_q - c0;
				res_q[bit_q] <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

// ===== sv/stn_div.sv =====
`default_nettype none
module stn_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [stn_pkg::MAG_W-1:0] v,
	input  wire logic [stn_pkg::MAG_W-1:0] h,
	output logic                           done,
	output logic      [stn_pkg::MAG_W-1:0] q
);

	logic                           busy_q;
	logic                           done_q;
	logic [stn_pkg::BITCNT_W-1:0]   cnt_q;
	logic [stn_pkg::MAG_W:0]        rem_q;
	logic [stn_pkg::MAG_W:0]        div_q;
	logic [stn_pkg::MAG_W-1:0]      q_q;
	logic [stn_pkg::MAG_W:0]        sum;
	logic [stn_pkg::MAG_W+1:0]      r2;
	logic [stn_pkg::MAG_W+1:0]      diff;
	logic                           ge;

	assign sum  = {1'b0, v} + {1'b0, h};
	assign r2   = {rem_q, 1'b0};
	assign diff = r2 - {1'b0, div_q};
	assign ge   = r2 >= {1'b0, div_q};

	// control: special cases finish at once, else one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= stn_pkg::BITCNT_W'(stn_pkg::MAG_W - 1);
				if (sum == '0 || h == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division of v * 2^16 by v + h
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, v};
			div_q <= sum;
			if (sum == '0) begin
				q_q <= '0;
			end else if (h == '0) begin
				q_q <= '1;
			end else begin
				q_q <= '0;
			end
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[stn_pkg::MAG_W:0];
			end else begin
				rem_q <= r2[stn_pkg::MAG_W:0];
			end
			q_q <= {q_q[stn_pkg::MAG_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule
`default_nettype wire

// ===== sv/spectral_transientness_ratio_top.sv =====
// Spectral transientness ratio.
// Input stream: s_tdata carries one 16-bit magnitude of the newest frame,
// s_tlast marks the last bin of a frame. Each item gives one result on the
// output stream: m_tdata is v/(v+h) in Q0.16 for the same bin of the center
// frame (v: median along frequency, h: median along time), m_tlast marks the
// frame's last bin.
// One item at a time: s_tready is high only while the sequencer is idle.
// Processing makes one history memory read per window slot (nt slots for
// the time window, nf for the frequency window), a 16-step radix select
// shared by both medians and a 16-step divider, which finishes without
// stepping when v+h or h is zero. A new item can be taken in the same cycle
// that the result appears. The next item is taken once the result sits in
// the output register; if the receiver stalls with a result still held, the
// sequencer waits before loading the new one.
// Configuration (cfg_we, cfg_addr, cfg_wdata) must be written only while idle; the block does not enforce it.
// Reset empties the history counters and restores register defaults; the
// history memory itself is not cleared.
`default_nettype none
module spectral_transientness_ratio_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [15:0]                   s_tdata,   // magnitude[15:0]
	input  wire logic                          s_tlast,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [15:0]                   m_tdata,   // ratio[15:0]
	output logic                               m_tlast,
	input  wire logic                          cfg_we,
	input  wire logic [stn_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [stn_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int LW = stn_pkg::LEN_W;
	localparam int FW = stn_pkg::NFRM_W;
	localparam int NW = stn_pkg::NBIN_W;
	localparam int BW = stn_pkg::BIN_W;
	localparam int SW = stn_pkg::SLOT_W;
	localparam int JW = stn_pkg::NBIN_W + 1;

	// configuration registers
	logic [5:0]  tml_q, fml_q, hfr_q;
	logic [10:0] biu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tml_q <= 6'd17;
			fml_q <= 6'd23;
			biu_q <= 11'd1024;
			hfr_q <= 6'd33;
		end else if (cfg_we) begin
			case (cfg_addr)
				stn_pkg::REG_TIME_LEN: tml_q <= cfg_wdata[5:0];
				stn_pkg::REG_FREQ_LEN: fml_q <= cfg_wdata[5:0];
				stn_pkg::REG_BINS:     biu_q <= cfg_wdata[10:0];
				stn_pkg::REG_HIST:     hfr_q <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	// clamped settings
	logic [LW-1:0] nt, nf;
	logic [NW-1:0] nb;
	logic [FW-1:0] hf;

	always_comb begin
		nt = (tml_q == '0) ? LW'(1) :
			(tml_q > 6'(stn_pkg::MAX_MEDIAN)) ? LW'(stn_pkg::MAX_MEDIAN) : LW'(tml_q);
		nf = (fml_q == '0) ? LW'(1) :
			(fml_q > 6'(stn_pkg::MAX_MEDIAN)) ? LW'(stn_pkg::MAX_MEDIAN) : LW'(fml_q);
		nb = (biu_q == '0) ? NW'(1) :
			(biu_q > 11'(stn_pkg::MAX_BINS)) ? NW'(stn_pkg::MAX_BINS) : NW'(biu_q);
		hf = (hfr_q == '0) ? FW'(1) :
			(hfr_q > 6'(stn_pkg::HIST_FRAMES)) ? FW'(stn_pkg::HIST_FRAMES) : FW'(hfr_q);
	end

	// ring slot lying back positions behind the newest slot
	function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] newest,
		input logic [FW:0] back);
		logic [SW+1:0] tmp;
		tmp = (SW+2)'(newest) + (SW+2)'(stn_pkg::HIST_FRAMES) - (SW+2)'(back);
		if (tmp >= (SW+2)'(stn_pkg::HIST_FRAMES)) begin
			tmp = tmp - (SW+2)'(stn_pkg::HIST_FRAMES);
		end
		return tmp[SW-1:0];
	endfunction

	stn_pkg::state_t state_q, state_d;

	logic          accept;
	logic [BW-1:0] bin_q, i_q;
	logic [SW-1:0] slot_q;
	logic [FW-1:0] ff_q;
	logic          last_q;
	logic [LW:0]   t_q;
	logic          first;
	logic [SW-1:0] slot_nx;
	logic [FW-1:0] ff_inc, ff_nx;
	logic          last_nx;

	assign accept = s_tvalid && s_tready;

	// frame bookkeeping at accept
	always_comb begin
		first   = (bin_q == '0);
		slot_nx = slot_q;
		if (first) begin
			slot_nx = (slot_q == SW'(stn_pkg::HIST_FRAMES - 1)) ? '0 : slot_q + 1'b1;
		end
		ff_inc  = (first && ff_q < hf) ? ff_q + 1'b1 : ff_q;
		ff_nx   = (ff_inc > hf) ? hf : ff_inc;
		last_nx = s_tlast || ((NW'(bin_q) + NW'(1)) >= nb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q  <= '0;
			slot_q <= '0;
			ff_q   <= '0;
		end else if (accept) begin
			bin_q  <= last_nx ? '0 : bin_q + 1'b1;
			slot_q <= slot_nx;
			ff_q   <= ff_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			i_q    <= bin_q;
			last_q <= last_nx;
		end
	end

	// window slot address and validity for the current gather step
	logic          tgath, fgath;
	logic [LW-1:0] n_cur;
	logic [LW-1:0] half, two_half, hv, two_hv, col;
	logic          col_ok, is_newest;
	logic [LW:0]   jt;
	logic [JW-1:0] jp, jf;
	logic          use_t, use_f, issue, rd_use;
	logic [SW-1:0] rd_slot;
	logic [BW-1:0] rd_bin;

	always_comb begin
		tgath     = (state_q == stn_pkg::ST_TGATH);
		fgath     = (state_q == stn_pkg::ST_FGATH);
		n_cur     = fgath ? nf : nt;
		half      = nt >> 1;
		two_half  = {nt[LW-1:1], 1'b0};
		hv        = nf >> 1;
		two_hv    = {nf[LW-1:1], 1'b0};
		col       = half + 1'b1;
		col_ok    = (FW'(col) < ff_q);
		is_newest = (FW'(col) == ff_q - 1'b1);
		jt        = t_q + 1'b1;
		use_t     = (t_q < (LW+1)'(two_half)) && (FW'(jt) < ff_q);
		jp        = JW'(i_q) + JW'(t_q);
		jf        = jp - JW'(hv);
		use_f     = col_ok && (t_q < (LW+1)'(two_hv)) && (jp >= JW'(hv)) &&
			(jf < JW'(nb)) && (!is_newest || jf <= JW'(i_q));
		issue     = (tgath || fgath) && (t_q < (LW+1)'(n_cur));
		if (fgath) begin
			rd_use  = use_f;
			rd_slot = slot_of(slot_q, (FW+1)'(ff_q) - (FW+1)'(1) - (FW+1)'(col));
			rd_bin  = jf[BW-1:0];
		end else begin
			rd_use  = use_t;
			rd_slot = slot_of(slot_q, (FW+1)'(ff_q) - (FW+1)'(1) - (FW+1)'(jt));
			rd_bin  = i_q;
		end
	end

	// history memory
	logic [stn_pkg::MAG_W-1:0] rdata;

	stn_store u_store (
		.clk   (clk),
		.we    (accept),
		.waddr ({slot_nx, bin_q}),
		.wdata (s_tdata),
		.raddr ({rd_slot, rd_bin}),
		.rdata (rdata)
	);

	// read tag pipeline and window write-back
	logic                     rd_v_s1, rd_use_s1;
	logic [stn_pkg::WIDX_W-1:0] rd_idx_s1;
	stn_pkg::win_t            win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_use_s1 <= rd_use;
		rd_idx_s1 <= t_q[stn_pkg::WIDX_W-1:0];
		if (rd_v_s1) begin
			win_q[rd_idx_s1] <= rd_use_s1 ? rdata : '0;
		end
	end

	// gather step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= '0;
		end else if (issue) begin
			t_q <= t_q + 1'b1;
		end else begin
			t_q <= '0;
		end
	end

	// shared median unit and divider
	logic                      sel_start, sel_done, div_start, div_done, out_load;
	logic [stn_pkg::MAG_W-1:0] sel_res, div_q, h_q;

	stn_sel u_sel (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sel_start),
		.n      (n_cur),
		.win    (win_q),
		.done   (sel_done),
		.res    (sel_res)
	);

	stn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.v      (sel_res),
		.h      (h_q),
		.done   (div_done),
		.q      (div_q)
	);

	always_ff @(posedge clk) begin
		if (state_q == stn_pkg::ST_TSEL && sel_done) begin
			h_q <= sel_res;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			stn_pkg::ST_IDLE:  if (s_tvalid) state_d = stn_pkg::ST_TGATH;
			stn_pkg::ST_TGATH: if (!issue) state_d = stn_pkg::ST_TSEL;
			stn_pkg::ST_TSEL:  if (sel_done) state_d = stn_pkg::ST_FGATH;
			stn_pkg::ST_FGATH: if (!issue) state_d = stn_pkg::ST_FSEL;
			stn_pkg::ST_FSEL:  if (sel_done) state_d = stn_pkg::ST_DIV;
			stn_pkg::ST_DIV:   if (div_done) state_d = stn_pkg::ST_DONE;
			stn_pkg::ST_DONE:  if (out_load) state_d = stn_pkg::ST_IDLE;
			default:           state_d = stn_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = (state_q == stn_pkg::ST_IDLE);
		sel_start = (tgath || fgath) && !issue;
		div_start = (state_q == stn_pkg::ST_FSEL) && sel_done;
		out_load  = (state_q == stn_pkg::ST_DONE) && (!m_tvalid || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output register
	logic out_v_q;
	logic [stn_pkg::MAG_W-1:0] out_d_q;
	logic out_l_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_d_q <= div_q;
			out_l_q <= last_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tlast  = out_l_q;

	// checks
	a_sel_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		sel_done |-> (state_q == stn_pkg::ST_TSEL || state_q == stn_pkg::ST_FSEL))
		else $error("median done outside a select state");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == stn_pkg::ST_DIV))
		else $error("divider done outside the divide state");

	a_ring_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (slot_q < SW'(stn_pkg::HIST_FRAMES) &&
			ff_q <= FW'(stn_pkg::HIST_FRAMES) && ff_q != '0))
		else $error("history ring state out of range");

endmodule
`default_nettype wire
